FILE: rtl/core/vrl_pkg.sv
// shared types, constants and elaboration-time table functions for the voice ring led frame
package vrl_pkg;

  localparam int GRID_SIZE_DEF  = 5;
  localparam int SINE_DEPTH_DEF = 256;

  localparam int LVL_W     = 11;
  localparam int TIME_W    = 32;
  localparam int GAIN_W    = 8;
  localparam int RAD_W     = 16;
  localparam int DIST_W    = 17;  // covers the corner distance of the largest grid
  localparam int COORD_W   = 3;
  localparam int BRIGHT_W  = 8;
  localparam int SINE_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;

  localparam logic [GAIN_W-1:0] ATTACK_RESET  = 8'd90;
  localparam logic [GAIN_W-1:0] RELEASE_RESET = 8'd15;
  localparam logic [RAD_W-1:0]  INNER_RESET   = 16'd2458;
  localparam logic [RAD_W-1:0]  OUTER_RESET   = 16'd6554;

  localparam logic [LVL_W-1:0] LEVEL_MAX     = 11'd1152;
  localparam logic [31:0]      PHASE_PER_MS  = 32'd1913983;
  localparam logic [RAD_W-1:0] TARGET_BASE   = 16'd2458;
  localparam logic [RAD_W-1:0] OUTER_OFFSET  = 16'd4096;
  localparam logic [15:0]      BRIGHT_I_BASE = 16'd28160;
  localparam logic [15:0]      BRIGHT_E_BASE = 16'd15360;
  localparam logic [DIST_W-1:0] HALO_ONE     = 17'd8192;

  // reciprocal multipliers: floor(n/d) = (n * RECIP) >> shift over the value ranges used
  localparam logic [18:0] RECIP15 = 19'd279621;   // shift 22
  localparam logic [18:0] RECIP9  = 19'd466034;   // shift 22
  localparam logic [20:0] RECIP7  = 21'd1198373;  // shift 23
  localparam logic [15:0] RECIP20 = 16'd52429;    // shift 20

  localparam longint unsigned POLY_A   = 64'd102944;
  localparam longint unsigned POLY_B   = 64'd37408;
  localparam longint unsigned POLY_C   = 64'd4640;
  localparam longint unsigned SINE_ONE = 64'd16384;

  typedef struct packed {
    logic load;
    logic phase;
    logic index;
    logic lookup;
    logic breath;
    logic target;
    logic step;
    logic update;
    logic issue;
    logic last;
  } vrl_cmd_t;

  typedef struct packed {
    logic adv;
    logic frame_done;
  } vrl_stat_t;

  // quarter-wave polynomial, u in Q16, result in Q1.14 with the quadrant sign applied
  function automatic logic signed [SINE_W-1:0] sine_poly(input longint unsigned u,
                                                         input logic neg);
    longint unsigned u2;
    longint unsigned t1;
    longint unsigned t2;
    longint unsigned s;
    logic signed [SINE_W-1:0] mag;
    u2 = (u * u) >> 16;
    t1 = POLY_B - ((POLY_C * u2) >> 16);
    t2 = POLY_A - ((u2 * t1) >> 16);
    s  = (u * t2) >> 18;
    if (s > SINE_ONE) begin
      s = SINE_ONE;
    end
    mag = SINE_W'(s);
    return neg ? -mag : mag;
  endfunction

  // bitwise integer square root, only used for constant tables
  function automatic longint unsigned isqrt_const(input longint unsigned v);
    longint unsigned r;
    longint unsigned rem;
    longint unsigned bit_v;
    r   = 64'd0;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      bit_v = 64'd1 << (62 - 2 * i);
      if (rem >= r + bit_v) begin
        rem = rem - (r + bit_v);
        r   = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/voice_ring_led_frame.sv
// top level of the voice ring led frame renderer
// One frame item (voice level, time in ms) yields GRID_SIZE*GRID_SIZE pixel items in row order,
// the final one flagged by last_pixel. After an item is taken, the setup states form the
// breathing phase, the sine lookup, the target radius and the new ring radii; the pixels then
// leave a five-stage halo pipeline at one per cycle while out_stall is low. in_stall stays high
// until the last pixel of the frame has been taken.
// attack_gain (index 0) and release_gain (index 1) are written through the cfg port; the user
// must do so only while idle, as the block itself does not enforce it.
module voice_ring_led_frame #(
  parameter int GRID_SIZE        = vrl_pkg::GRID_SIZE_DEF,
  parameter int SINE_TABLE_DEPTH = vrl_pkg::SINE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [vrl_pkg::LVL_W-1:0]     voice_level,
  input  logic [vrl_pkg::TIME_W-1:0]    time_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vrl_pkg::COORD_W-1:0]   pixel_x,
  output logic [vrl_pkg::COORD_W-1:0]   pixel_y,
  output logic [vrl_pkg::BRIGHT_W-1:0]  brightness,
  output logic                          last_pixel,
  input  logic                          cfg_wr_en,
  input  logic [vrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vrl_pkg::GAIN_W-1:0]    cfg_data
);
  import vrl_pkg::*;

  localparam int CNT_W = $clog2(GRID_SIZE);

  vrl_cmd_t         cmd;
  vrl_stat_t        stat;
  logic [CNT_W-1:0] pix_x;
  logic [CNT_W-1:0] pix_y;

  vrl_ctrl #(
    .GRID_SIZE (GRID_SIZE)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd),
    .pix_x    (pix_x),
    .pix_y    (pix_y)
  );

  vrl_dp #(
    .GRID_SIZE        (GRID_SIZE),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .pix_x       (pix_x),
    .pix_y       (pix_y),
    .voice_level (voice_level),
    .time_ms     (time_ms),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .brightness  (brightness),
    .last_pixel  (last_pixel)
  );

endmodule

FILE: rtl/core/vrl_ctrl.sv
// frame sequencer: setup steps, pixel scan and drain
module vrl_ctrl #(
  parameter int GRID_SIZE = vrl_pkg::GRID_SIZE_DEF,
  localparam int CNT_W = $clog2(GRID_SIZE)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  vrl_pkg::vrl_stat_t stat,
  output vrl_pkg::vrl_cmd_t  cmd,
  output logic [CNT_W-1:0]   pix_x,
  output logic [CNT_W-1:0]   pix_y
);
  import vrl_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PHASE  = 4'd1;
  localparam logic [3:0] ST_INDEX  = 4'd2;
  localparam logic [3:0] ST_LOOKUP = 4'd3;
  localparam logic [3:0] ST_BREATH = 4'd4;
  localparam logic [3:0] ST_TARGET = 4'd5;
  localparam logic [3:0] ST_STEP   = 4'd6;
  localparam logic [3:0] ST_UPDATE = 4'd7;
  localparam logic [3:0] ST_PIXEL  = 4'd8;
  localparam logic [3:0] ST_DRAIN  = 4'd9;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(GRID_SIZE - 1);

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] x_cnt;
  logic [CNT_W-1:0] x_cnt_next;
  logic [CNT_W-1:0] y_cnt;
  logic [CNT_W-1:0] y_cnt_next;
  logic             last_pix;

  assign last_pix = (x_cnt == CNT_MAX) && (y_cnt == CNT_MAX);

  always_comb begin
    state_next = state;
    x_cnt_next = x_cnt;
    y_cnt_next = y_cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PHASE;
        end
      end
      ST_PHASE: begin
        cmd.phase  = 1'b1;
        state_next = ST_INDEX;
      end
      ST_INDEX: begin
        cmd.index  = 1'b1;
        state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_BREATH;
      end
      ST_BREATH: begin
        cmd.breath = 1'b1;
        state_next = ST_TARGET;
      end
      ST_TARGET: begin
        cmd.target = 1'b1;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_PIXEL;
      end
      ST_PIXEL: begin
        cmd.issue = 1'b1;
        cmd.last  = last_pix;
        if (stat.adv) begin
          if (last_pix) begin
            x_cnt_next = '0;
            y_cnt_next = '0;
            state_next = ST_DRAIN;
          end else if (x_cnt == CNT_MAX) begin
            x_cnt_next = '0;
            y_cnt_next = y_cnt + 1'b1;
          end else begin
            x_cnt_next = x_cnt + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (stat.frame_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      x_cnt <= '0;
      y_cnt <= '0;
    end else begin
      state <= state_next;
      x_cnt <= x_cnt_next;
      y_cnt <= y_cnt_next;
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign pix_x    = x_cnt;
  assign pix_y    = y_cnt;

endmodule

FILE: rtl/core/vrl_dp.sv
// datapath: gains, frame setup arithmetic, ring radii and the pixel halo pipeline
module vrl_dp #(
  parameter int GRID_SIZE        = vrl_pkg::GRID_SIZE_DEF,
  parameter int SINE_TABLE_DEPTH = vrl_pkg::SINE_DEPTH_DEF,
  localparam int CNT_W = $clog2(GRID_SIZE)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  vrl_pkg::vrl_cmd_t               cmd,
  output vrl_pkg::vrl_stat_t              stat,
  input  logic [CNT_W-1:0]                pix_x,
  input  logic [CNT_W-1:0]                pix_y,
  input  logic [vrl_pkg::LVL_W-1:0]       voice_level,
  input  logic [vrl_pkg::TIME_W-1:0]      time_ms,
  input  logic                            cfg_wr_en,
  input  logic [vrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vrl_pkg::GAIN_W-1:0]      cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [vrl_pkg::COORD_W-1:0]     pixel_x,
  output logic [vrl_pkg::COORD_W-1:0]     pixel_y,
  output logic [vrl_pkg::BRIGHT_W-1:0]    brightness,
  output logic                            last_pixel
);
  import vrl_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

  // constant tables
  logic signed [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH];
  logic [DIST_W-1:0]        dist_rom [GRID_SIZE][GRID_SIZE];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
    localparam longint unsigned Q4   = 64'(g) * 64'd4;
    localparam longint unsigned QUAD = Q4 / SINE_TABLE_DEPTH;
    localparam longint unsigned REM  = Q4 % SINE_TABLE_DEPTH;
    localparam longint unsigned UR   = (REM << 16) / SINE_TABLE_DEPTH;
    localparam longint unsigned UU   = (QUAD % 2 == 1) ? 64'd65536 - UR : UR;
    assign sine_rom[g] = sine_poly(UU, QUAD >= 2);
  end

  for (genvar gy = 0; gy < GRID_SIZE; gy++) begin : g_row
    for (genvar gx = 0; gx < GRID_SIZE; gx++) begin : g_col
      localparam int DX = 2 * gx - (GRID_SIZE - 1);
      localparam int DY = 2 * gy - (GRID_SIZE - 1);
      localparam longint unsigned SQ = 64'(DX * DX + DY * DY);
      assign dist_rom[gy][gx] = DIST_W'(isqrt_const(SQ << 24));
    end
  end

  // configuration
  logic [GAIN_W-1:0] attack_gain;
  logic [GAIN_W-1:0] release_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_gain  <= ATTACK_RESET;
      release_gain <= RELEASE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ATTACK:  attack_gain  <= cfg_data;
        REG_RELEASE: release_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame setup
  logic [LVL_W-1:0]  lvl_clamp;
  logic [TIME_W-1:0] time_q;
  logic [17:0]       lvl_x224;
  logic [18:0]       lvl_x290;
  logic [17:0]       lvl_x160;
  logic [31:0]       turns;
  logic [14:0]       lvl_term;
  logic [15:0]       bright_i;
  logic [15:0]       bright_e;
  logic [IDX_W-1:0]  sine_idx;
  logic signed [SINE_W-1:0] sine_val;
  logic [9:0]        breath;
  logic              breath_neg;
  logic [RAD_W-1:0]  target;
  logic [RAD_W-1:0]  step_i;
  logic [RAD_W-1:0]  step_o;
  logic              neg_i;
  logic              neg_o;
  logic [RAD_W-1:0]  inner_radius;
  logic [RAD_W-1:0]  outer_radius;

  logic [63:0]       prod_turns;
  logic [36:0]       prod_lvl;
  logic [37:0]       prod_bi;
  logic [36:0]       prod_be;
  logic [63:0]       prod_idx;
  logic [14:0]       sine_mag;
  logic [30:0]       prod_br;
  logic [RAD_W-1:0]  target_base;
  logic [RAD_W-1:0]  goal_o;
  logic signed [RAD_W:0] diff_i;
  logic signed [RAD_W:0] diff_o;
  logic [RAD_W-1:0]  mag_i;
  logic [RAD_W-1:0]  mag_o;
  logic [23:0]       prod_si;
  logic [23:0]       prod_so;

  function automatic logic [RAD_W-1:0] apply_step(input logic [RAD_W-1:0] r,
                                                  input logic [RAD_W-1:0] st,
                                                  input logic neg);
    if (neg) begin
      return (st > r) ? '0 : r - st;
    end
    return r + st;
  endfunction

  always_comb begin
    lvl_clamp   = (voice_level > LEVEL_MAX) ? LEVEL_MAX : voice_level;
    prod_turns  = 64'(time_q) * 64'(PHASE_PER_MS);
    prod_lvl    = 37'(lvl_x224) * 37'(RECIP15);
    prod_bi     = 38'(lvl_x290) * 38'(RECIP9);
    prod_be     = 37'(lvl_x160) * 37'(RECIP9);
    prod_idx    = 64'(turns) * 64'(SINE_TABLE_DEPTH);
    sine_mag    = sine_val[SINE_W-1] ? 15'(-sine_val) : 15'(sine_val);
    prod_br     = 31'(sine_mag) * 31'(RECIP20);
    target_base = TARGET_BASE + 16'(lvl_term);
    goal_o      = target + OUTER_OFFSET;
    diff_i      = $signed({1'b0, target}) - $signed({1'b0, inner_radius});
    diff_o      = $signed({1'b0, goal_o}) - $signed({1'b0, outer_radius});
    mag_i       = diff_i[RAD_W] ? RAD_W'(-diff_i) : RAD_W'(diff_i);
    mag_o       = diff_o[RAD_W] ? RAD_W'(-diff_o) : RAD_W'(diff_o);
    prod_si     = 24'(mag_i) * 24'(attack_gain);
    prod_so     = 24'(mag_o) * 24'(release_gain);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      time_q   <= time_ms;
      lvl_x224 <= 18'(lvl_clamp) * 18'd224;
      lvl_x290 <= 19'(lvl_clamp) * 19'd290;
      lvl_x160 <= 18'(lvl_clamp) * 18'd160;
    end
    if (cmd.phase) begin
      turns    <= prod_turns[31:0];
      lvl_term <= 15'(prod_lvl >> 22);
      bright_i <= BRIGHT_I_BASE + 16'(prod_bi >> 22);
      bright_e <= BRIGHT_E_BASE + 16'(prod_be >> 22);
    end
    if (cmd.index) begin
      sine_idx <= prod_idx[32 +: IDX_W];
    end
    if (cmd.lookup) begin
      sine_val <= sine_rom[sine_idx];
    end
    if (cmd.breath) begin
      breath     <= 10'(prod_br >> 20);
      breath_neg <= sine_val[SINE_W-1];
    end
    if (cmd.target) begin
      target <= breath_neg ? target_base - 16'(breath) : target_base + 16'(breath);
    end
    if (cmd.step) begin
      step_i <= prod_si[23:8];
      step_o <= prod_so[23:8];
      neg_i  <= diff_i[RAD_W];
      neg_o  <= diff_o[RAD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_radius <= INNER_RESET;
      outer_radius <= OUTER_RESET;
    end else if (cmd.update) begin
      inner_radius <= apply_step(inner_radius, step_i, neg_i);
      outer_radius <= apply_step(outer_radius, step_o, neg_o);
    end
  end

  // pixel pipeline: distance, falloff, square, scale, sum
  logic              adv;
  logic              v1, v2, v3, v4;
  logic [CNT_W-1:0]  x1, x2, x3, x4;
  logic [CNT_W-1:0]  y1, y2, y3, y4;
  logic              l1, l2, l3, l4;
  logic [DIST_W-1:0] di1;
  logic [DIST_W-1:0] do1;
  logic [DIST_W-1:0] fall2;
  logic [13:0]       co2;
  logic [26:0]       csq_i3;
  logic [26:0]       csq_o3;
  logic [7:0]        halo_i4;
  logic [7:0]        halo_o4;

  logic [DIST_W-1:0] dist_cur;
  logic [DIST_W-1:0] ri_ext;
  logic [DIST_W-1:0] ro_ext;
  logic [19:0]       n10;
  logic [40:0]       prod_f;
  logic [13:0]       ci;
  logic [42:0]       prod_hi;
  logic [42:0]       prod_ho;
  logic [8:0]        sum;

  assign adv = !out_valid || !out_stall;

  always_comb begin
    dist_cur = dist_rom[pix_y][pix_x];
    ri_ext   = DIST_W'(inner_radius);
    ro_ext   = DIST_W'(outer_radius);
    n10      = 20'(di1) * 20'd10;
    prod_f   = 41'(n10) * 41'(RECIP7);
    ci       = (fall2 >= HALO_ONE) ? '0 : 14'(HALO_ONE - fall2);
    prod_hi  = 43'(bright_i) * 43'(csq_i3);
    prod_ho  = 43'(bright_e) * 43'(csq_o3);
    sum      = 9'(halo_i4) + 9'(halo_o4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= cmd.issue;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1  <= pix_x;
      y1  <= pix_y;
      l1  <= cmd.last;
      di1 <= (dist_cur >= ri_ext) ? dist_cur - ri_ext : ri_ext - dist_cur;
      do1 <= (dist_cur >= ro_ext) ? dist_cur - ro_ext : ro_ext - dist_cur;

      x2    <= x1;
      y2    <= y1;
      l2    <= l1;
      fall2 <= DIST_W'(prod_f >> 23);
      co2   <= (do1 >= HALO_ONE) ? '0 : 14'(HALO_ONE - do1);

      x3     <= x2;
      y3     <= y2;
      l3     <= l2;
      csq_i3 <= 27'(ci) * 27'(ci);
      csq_o3 <= 27'(co2) * 27'(co2);

      x4      <= x3;
      y4      <= y3;
      l4      <= l3;
      halo_i4 <= prod_hi[41:34];
      halo_o4 <= prod_ho[41:34];

      pixel_x    <= COORD_W'(x4);
      pixel_y    <= COORD_W'(y4);
      last_pixel <= l4;
      brightness <= sum[8] ? 8'hFF : sum[7:0];
    end
  end

  assign stat.adv        = adv;
  assign stat.frame_done = out_valid && !out_stall && last_pixel;

endmodule

FILE: sim/tb_voice_ring_led_frame.sv
// testbench for the voice ring led frame renderer: frame predictor, pixel checker, stall traffic
module tb_voice_ring_led_frame;
  timeunit 1ns;
  timeprecision 1ps;

  import vrl_pkg::*;

  localparam int GRID        = GRID_SIZE_DEF;
  localparam int SINE_N      = SINE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_WAIT  = 40;

  // indexes past the two gain registers, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [BRIGHT_W-1:0] bright;
    logic                last;
  } pixel_t;

  class ring_frame_board;
    int unsigned att_gain;
    int unsigned rel_gain;
    int unsigned inner_r;
    int unsigned outer_r;
    int          sine_q14[SINE_N];
    pixel_t      frame_pixels[$];
    int unsigned frames;
    int unsigned pixels_seen;
    int unsigned errors;

    function new();
      longint unsigned q4, quad, rem, u, u2, t1, t2, s;
      att_gain = ATTACK_RESET;
      rel_gain = RELEASE_RESET;
      inner_r  = INNER_RESET;
      outer_r  = OUTER_RESET;
      frames = 0;
      pixels_seen = 0;
      errors = 0;
      // quarter-wave polynomial, mirrored for odd quadrants, negated for the second half
      for (int i = 0; i < SINE_N; i++) begin
        q4   = i * 4;
        quad = q4 / SINE_N;
        rem  = q4 % SINE_N;
        u    = (rem << 16) / SINE_N;
        if (quad[0]) begin
          u = 65536 - u;
        end
        u2 = (u * u) >> 16;
        t1 = POLY_B - ((POLY_C * u2) >> 16);
        t2 = POLY_A - ((u2 * t1) >> 16);
        s  = (u * t2) >> 18;
        if (s > SINE_ONE) begin
          s = SINE_ONE;
        end
        sine_q14[i] = (quad >= 2) ? -int'(s) : int'(s);
      end
    endfunction

    task report(string what);
      errors++;
      $display("ERROR %0t: %s", $time, what);
    endtask

    function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
      case (idx)
        REG_ATTACK: att_gain = val;
        REG_RELEASE: rel_gain = val;
        default: ;
      endcase
    endfunction

    function int unsigned ease(int unsigned r, int goal, int unsigned gain);
      int          diff;
      int          nr;
      int unsigned mag;
      int unsigned stp;
      diff = goal - int'(r);
      mag  = (diff < 0) ? -diff : diff;
      stp  = (mag * gain) >> 8;
      nr   = (diff < 0) ? int'(r) - int'(stp) : int'(r) + int'(stp);
      if (nr < 0) begin
        nr = 0;
      end
      return nr & 32'hFFFF;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) begin
          r = t;
        end
      end
      return r;
    endfunction

    function int unsigned glow(longint unsigned d, int unsigned r, longint unsigned level,
                               bit narrow);
      longint unsigned diff;
      longint unsigned fall;
      longint unsigned c;
      diff = (d > r) ? d - r : r - d;
      fall = narrow ? (diff * 10) / 7 : diff;
      if (fall >= 8192) begin
        return 0;
      end
      c = 8192 - fall;
      return int'((level * c * c) >> 34);
    endfunction

    // advances both rings and queues the whole grid of brightnesses for one frame
    function void render_frame(logic [LVL_W-1:0] lvl_in, logic [TIME_W-1:0] ms);
      longint unsigned lvl, turns, bi, be, sq, d;
      int          idx, s, brth, tgt, dx, dy;
      int unsigned sum;
      pixel_t      px;
      lvl = lvl_in;
      if (lvl > LEVEL_MAX) begin
        lvl = LEVEL_MAX;
      end
      turns = ms;
      turns = (turns * PHASE_PER_MS) & 64'hFFFF_FFFF;
      idx   = int'((turns * SINE_N) >> 32);
      s     = sine_q14[idx];
      brth  = ((s < 0) ? -s : s) / 20;
      if (s < 0) begin
        brth = -brth;
      end
      tgt = int'(TARGET_BASE) + int'((lvl * 224) / 15) + brth;
      inner_r = ease(inner_r, tgt, att_gain);
      outer_r = ease(outer_r, tgt + int'(OUTER_OFFSET), rel_gain);
      bi = BRIGHT_I_BASE + (lvl * 290) / 9;
      be = BRIGHT_E_BASE + (lvl * 160) / 9;
      for (int y = 0; y < GRID; y++) begin
        for (int x = 0; x < GRID; x++) begin
          dx  = 2 * x - (GRID - 1);
          dy  = 2 * y - (GRID - 1);
          sq  = dx * dx + dy * dy;
          d   = root_floor(sq << 24);
          sum = glow(d, inner_r, bi, 1'b1) + glow(d, outer_r, be, 1'b0);
          px.x      = COORD_W'(x);
          px.y      = COORD_W'(y);
          px.bright = (sum > 255) ? 8'd255 : sum[7:0];
          px.last   = (x == GRID - 1) && (y == GRID - 1);
          frame_pixels.push_back(px);
        end
      end
      frames++;
    endfunction

    task match_pixel(pixel_t got);
      pixel_t want;
      pixels_seen++;
      if (frame_pixels.size() == 0) begin
        report($sformatf("pixel (%0d,%0d) arrived with no frame pending", got.x, got.y));
        return;
      end
      want = frame_pixels.pop_front();
      if (got.x !== want.x) begin
        report($sformatf("pixel_x got %0d want %0d", got.x, want.x));
      end
      if (got.y !== want.y) begin
        report($sformatf("pixel_y got %0d want %0d", got.y, want.y));
      end
      if (got.bright !== want.bright) begin
        report($sformatf("brightness at (%0d,%0d) got %0d want %0d",
                         want.x, want.y, got.bright, want.bright));
      end
      if (got.last !== want.last) begin
        report($sformatf("last_pixel at (%0d,%0d) got %0b want %0b",
                         want.x, want.y, got.last, want.last));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [LVL_W-1:0]     voice_level = '0;
  logic [TIME_W-1:0]    time_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COORD_W-1:0]   pixel_x;
  logic [COORD_W-1:0]   pixel_y;
  logic [BRIGHT_W-1:0]  brightness;
  logic                 last_pixel;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data = '0;

  ring_frame_board board;
  int               send_idle = 0;
  int               recv_idle = 0;
  logic             hold_on = 1'b0;
  int unsigned      cycles = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  voice_ring_led_frame dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .voice_level(voice_level),
    .time_ms    (time_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .brightness (brightness),
    .last_pixel (last_pixel),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= hold_on || ($urandom_range(0, 99) < recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.match_pixel('{x: pixel_x, y: pixel_y, bright: brightness, last: last_pixel});
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d pixels outstanding",
               cycles, board.frame_pixels.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_frame(input logic [LVL_W-1:0] lvl, input logic [TIME_W-1:0] ms);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid    <= 1'b0;
      voice_level <= LVL_W'($urandom());
      time_ms     <= $urandom();
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    voice_level <= lvl;
    time_ms     <= ms;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    board.render_frame(lvl, ms);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.set_gain(idx, val);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.frame_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    logic [LVL_W-1:0] lvl;
    int               pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        lvl = LVL_W'($urandom_range(0, LEVEL_MAX));
      end else if (pick < 82) begin
        lvl = LVL_W'($urandom_range(LEVEL_MAX + 1, 2047));
      end else if (pick < 91) begin
        lvl = '0;
      end else begin
        lvl = LEVEL_MAX;
      end
      // mostly a steady 16 ms frame clock, sometimes a jump anywhere
      if ($urandom_range(0, 2) != 0) begin
        clock_ms = clock_ms + 32'd16;
      end else begin
        clock_ms = $urandom();
      end
      send_frame(lvl, clock_ms);
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames at reset gains: level and time corners, sine quadrants
    send_frame(11'd0, 32'd0);
    send_frame(LEVEL_MAX, 32'd561);
    send_frame(LEVEL_MAX, 32'd1122);
    send_frame(LEVEL_MAX, 32'd1683);
    send_frame(LEVEL_MAX + 11'd1, 32'd2244);
    send_frame(11'h7FF, 32'hFFFF_FFFF);
    send_frame(11'h7FF, 32'h8000_0000);
    send_frame(11'd1, 32'd1);
    send_frame(LEVEL_MAX - 11'd1, 32'h5555_5555);
    send_frame(11'h2AA, 32'hAAAA_AAAA);
    send_frame(11'h555, 32'd2243);
    send_frame(11'd0, 32'hFFFF_FF00);
    repeat (4) send_frame(11'd0, $urandom());
    repeat (5) send_frame(LEVEL_MAX, $urandom());
    wait_drained();

    write_reg(REG_ATTACK, 8'd255);
    write_reg(REG_RELEASE, 8'd0);
    write_reg(REG_SPARE_A, 8'hA5);
    write_reg(REG_SPARE_B, 8'hFF);
    send_idle = 29;
    recv_idle = 88;
    run_random(120);
    wait_drained();

    write_reg(REG_ATTACK, 8'd0);
    write_reg(REG_RELEASE, 8'd255);
    send_idle = 88;
    recv_idle = 29;
    run_random(120);
    wait_drained();

    write_reg(REG_ATTACK, GAIN_W'($urandom_range(1, 254)));
    write_reg(REG_RELEASE, GAIN_W'($urandom_range(1, 254)));
    send_idle = 0;
    recv_idle = 0;
    // long receiver hold-off while frames keep coming
    fork
      begin
        @(negedge clk);
        hold_on <= 1'b1;
        repeat (300) @(negedge clk);
        hold_on <= 1'b0;
      end
    join_none
    run_random(110);
    wait_drained();

    $display("%0d frames, %0d pixels checked at reset gains and three written gain pairs",
             board.frames, board.pixels_seen);
    $display("stall mixes: sender-heavy, receiver-heavy, none, plus a 300-cycle hold-off");
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
